### hdl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the cursor line editor
// Key and character codes, the action codes of an input word, the read source codes and the control state type.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

	localparam int KEY_W  = 8;
	localparam int CHAR_W = 8;

	localparam logic [KEY_W-1:0]  KEY_LEFT     = 8'd60;
	localparam logic [KEY_W-1:0]  KEY_RIGHT    = 8'd62;
	localparam logic [KEY_W-1:0]  KEY_DELETE   = 8'd45;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;

	localparam logic ACT_KEY   = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	// Which store a pending read came from.
	localparam logic SRC_LEFT  = 1'b0;
	localparam logic SRC_RIGHT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOVE,
		ST_FL_ISSUE,
		ST_FL_LOAD
	} state_t;

endpackage

`default_nettype wire

### hdl/cle_if.sv
// ----------------------------------------------------------------------------
// cle_in_if / cle_out_if: valid/ready channels of the cursor line editor
// The input channel carries keystroke words, the output channel line text.
// ----------------------------------------------------------------------------
`default_nettype none

interface cle_in_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [cle_pkg::KEY_W-1:0]  key;

	modport source (output valid, output action, output key, input ready);
	modport sink   (input valid, input action, input key, output ready);
endinterface

interface cle_out_if;
	logic                       valid;
	logic                       ready;
	logic [cle_pkg::CHAR_W-1:0] out_char;
	logic                       last;
	logic                       dropped;

	modport source (output valid, output out_char, output last, output dropped, input ready);
	modport sink   (input valid, input out_char, input last, input dropped, output ready);
endinterface

`default_nettype wire

### hdl/cle_ram.sv
// ----------------------------------------------------------------------------
// cle_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hdl/cursor_line_editor_top.sv
// ----------------------------------------------------------------------------
// cursor_line_editor_top: keystroke line editor with a cursor (gap buffer)
//
// Words arrive on keys (action, key). A keystroke word inserts its byte at the
// cursor, or with '<' / '>' moves the cursor, or with '-' deletes left of it.
// Inserts, deletes and ignored keys are done in ST_IDLE; a cursor move also
// passes ST_MOVE, since the character is read from one store and written to
// the other, and the store read is registered. Keystrokes give no output word.
// A flush word (action 1) emits the line on text, left part then right part,
// then a newline with last set and dropped telling whether an insert was lost
// to a full line. Each character is first read from its store (ST_FL_ISSUE) and
// then loaded into the output register (ST_FL_LOAD), one after the other;
// the block takes no new word until the newline is in the output register.
// When text stalls, the output register holds its word and the flush waits;
// keystrokes are still taken while the newline waits to be collected.
// Reset clears the counts and the dropped flag; the two stores are left as
// they are and are never read beyond what has been written.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_line_editor_top #(
	parameter int LINE_DEPTH = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	cle_in_if.sink    keys,
	cle_out_if.source text
);

	import cle_pkg::*;

	localparam int CW = $clog2(LINE_DEPTH + 1);
	localparam int AW = $clog2(LINE_DEPTH);

	state_t          state_q, state_d;
	logic [CW-1:0]   lc_q, lc_d;
	logic [CW-1:0]   rc_q, rc_d;
	logic [CW-1:0]   idx_q, idx_d;
	logic            ovf_q, ovf_d;
	logic            src_q, src_d;

	logic [CW:0]     sum;
	logic [CW-1:0]   lc_m1, rc_m1;
	logic [CW:0]     rpos;
	logic            load_ok;

	logic              l_we, l_re, r_we, r_re;
	logic [AW-1:0]     l_waddr, l_raddr, r_waddr, r_raddr;
	logic [CHAR_W-1:0] l_wdata, r_wdata, l_rdata, r_rdata;

	logic              out_load;
	logic [CHAR_W-1:0] char_d;
	logic              last_d, drop_d;
	logic              oval_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q, drop_q;

	cle_ram #(.WIDTH(CHAR_W), .DEPTH(LINE_DEPTH)) u_left (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.re    (l_re),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	cle_ram #(.WIDTH(CHAR_W), .DEPTH(LINE_DEPTH)) u_right (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.re    (r_re),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	assign sum     = {1'b0, lc_q} + {1'b0, rc_q};
	assign lc_m1   = lc_q - 1'b1;
	assign rc_m1   = rc_q - 1'b1;
	// The right part leaves in reverse: the entry nearest the cursor first.
	assign rpos    = sum - 1'b1 - {1'b0, idx_q};
	assign load_ok = !oval_q || text.ready;

	assign keys.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lc_q    <= '0;
			rc_q    <= '0;
			idx_q   <= '0;
			ovf_q   <= 1'b0;
			src_q   <= SRC_LEFT;
		end else begin
			state_q <= state_d;
			lc_q    <= lc_d;
			rc_q    <= rc_d;
			idx_q   <= idx_d;
			ovf_q   <= ovf_d;
			src_q   <= src_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		lc_d     = lc_q;
		rc_d     = rc_q;
		idx_d    = idx_q;
		ovf_d    = ovf_q;
		src_d    = src_q;
		l_we     = 1'b0;
		l_waddr  = lc_q[AW-1:0];
		l_wdata  = keys.key;
		l_re     = 1'b0;
		l_raddr  = lc_m1[AW-1:0];
		r_we     = 1'b0;
		r_waddr  = rc_q[AW-1:0];
		r_wdata  = l_rdata;
		r_re     = 1'b0;
		r_raddr  = rc_m1[AW-1:0];
		out_load = 1'b0;
		char_d   = src_q == SRC_RIGHT ? r_rdata : l_rdata;
		last_d   = 1'b0;
		drop_d   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (keys.valid) begin
					if (keys.action == ACT_FLUSH) begin
						idx_d   = '0;
						state_d = ST_FL_ISSUE;
					end else begin
						unique case (keys.key)
							KEY_LEFT: begin
								if (lc_q != '0 && rc_q < CW'(LINE_DEPTH)) begin
									l_re    = 1'b1;
									lc_d    = lc_m1;
									src_d   = SRC_LEFT;
									state_d = ST_MOVE;
								end
							end
							KEY_RIGHT: begin
								if (rc_q != '0 && lc_q < CW'(LINE_DEPTH)) begin
									r_re    = 1'b1;
									rc_d    = rc_m1;
									src_d   = SRC_RIGHT;
									state_d = ST_MOVE;
								end
							end
							KEY_DELETE: begin
								if (lc_q != '0) begin
									lc_d = lc_m1;
								end
							end
							default: begin
								if (sum < (CW+1)'(LINE_DEPTH)) begin
									l_we = 1'b1;
									lc_d = lc_q + 1'b1;
								end else begin
									ovf_d = 1'b1;
								end
							end
						endcase
					end
				end
			end
			ST_MOVE: begin
				// The character read last cycle lands on top of the other stack.
				if (src_q == SRC_LEFT) begin
					r_we    = 1'b1;
					r_wdata = l_rdata;
					rc_d    = rc_q + 1'b1;
				end else begin
					l_we    = 1'b1;
					l_wdata = r_rdata;
					lc_d    = lc_q + 1'b1;
				end
				state_d = ST_IDLE;
			end
			ST_FL_ISSUE: begin
				if (idx_q < lc_q) begin
					l_re    = 1'b1;
					l_raddr = idx_q[AW-1:0];
					src_d   = SRC_LEFT;
					state_d = ST_FL_LOAD;
				end else if ({1'b0, idx_q} < sum) begin
					r_re    = 1'b1;
					r_raddr = rpos[AW-1:0];
					src_d   = SRC_RIGHT;
					state_d = ST_FL_LOAD;
				end else if (load_ok) begin
					out_load = 1'b1;
					char_d   = CHAR_NEWLINE;
					last_d   = 1'b1;
					drop_d   = ovf_q;
					lc_d     = '0;
					rc_d     = '0;
					ovf_d    = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			ST_FL_LOAD: begin
				// Read data holds in the RAM until the next read, so a stall is safe.
				if (load_ok) begin
					out_load = 1'b1;
					idx_d    = idx_q + 1'b1;
					state_d  = ST_FL_ISSUE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (out_load) begin
			oval_q <= 1'b1;
		end else if (text.ready) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q <= char_d;
			last_q <= last_d;
			drop_q <= drop_d;
		end
	end

	assign text.valid    = oval_q;
	assign text.out_char = char_q;
	assign text.last     = last_q;
	assign text.dropped  = drop_q;

	// The two stacks together never hold more than a full line.
	a_line_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum <= (CW+1)'(LINE_DEPTH))
		else $error("line length beyond capacity");

	// Loading the newline empties the buffer and clears the dropped flag.
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_d) |=> (lc_q == '0 && rc_q == '0 && !ovf_q))
		else $error("buffer not cleared after newline");

	// A cursor move only follows an accepted word.
	a_move_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE) |-> $past(keys.valid && keys.ready))
		else $error("cursor move without an accepted word");

	// The output register is never overwritten while its word is pending.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!oval_q || text.ready))
		else $error("output word overwritten");

endmodule

`default_nettype wire
